// ===== hw/rtl/rgb_hue_rotate_core_defines.svh =====
// Assertion macros for the RTL file that checks its own logic (rgb_hue_rotate_core).
`ifndef RGB_HUE_ROTATE_CORE_DEFINES_SVH
`define RGB_HUE_ROTATE_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define RHR_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("rgb_hue_rotate_core: assertion failed");
`define RHR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("rgb_hue_rotate_core: assertion failed");
`else
`define RHR_ASSERT_NOW(label, ante, cons)
`define RHR_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ===== hw/rtl/rhr_pkg.sv =====
package rhr_pkg;

    localparam int CH_W   = 8;
    localparam int STEP_W = 9;
    localparam int Q_W    = 17;

    localparam int DEG60_I  = 60;
    localparam int DEG120_I = 120;
    localparam int DEG180_I = 180;
    localparam int DEG240_I = 240;
    localparam int DEG300_I = 300;
    localparam int DEG360_I = 360;

    typedef enum logic [1:0] {
        BASE_RED   = 2'd0,
        BASE_GREEN = 2'd1,
        BASE_BLUE  = 2'd2
    } base_t;

    typedef struct packed {
        base_t            base;
        logic             neg;
        logic             zero;
        logic [Q_W-1:0]   chroma;
        logic [Q_W-1:0]   mval;
    } hue_side_t;

    typedef struct packed {
        logic [2:0]       sector;
        logic [Q_W-1:0]   chroma;
        logic [Q_W-1:0]   mval;
    } comp_side_t;

    // Rounds b*65536/255 up: b*65536 = b*255*257 + b.
    function automatic logic [Q_W-1:0] q16_of_byte(input logic [CH_W-1:0] b);
        logic [Q_W-1:0] r;
        r = Q_W'(b) * Q_W'(257) + Q_W'(b != '0);
        return r;
    endfunction

endpackage

// ===== hw/rtl/rgb_hue_rotate_core.sv =====
// Pipeline: register stage A, the hue long divider's stages, then stages B to F, in that order.
// Throughput: one pixel per cycle unless stalled; the hue divider sets the depth, not the rate.
// A stalled result holds the whole pipeline; nothing is dropped or repeated.
// Reset: synchronous, active low on aresetn; clears all valid bits and sets hue_step to 210.
`include "rgb_hue_rotate_core_defines.svh"

module rgb_hue_rotate_core #(
    parameter int HUE_FRAC_BITS = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // red_in [7:0], green_in [15:8], blue_in [23:16]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // red_out [7:0], green_out [15:8], blue_out [23:16]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [8:0]  cfg_data   // hue_step
);

    localparam int F     = HUE_FRAC_BITS;
    localparam int HW    = 10 + F;
    localparam int NUMW  = 14 + F;
    localparam int TW    = 7 + F;
    localparam int GW    = 6 + F;
    localparam int PW    = rhr_pkg::Q_W + GW;
    localparam int Q_W   = rhr_pkg::Q_W;
    localparam int HSW   = $bits(rhr_pkg::hue_side_t);
    localparam int XMW   = 20;
    localparam int XRW   = 21;
    localparam int XPW   = XMW + XRW;
    localparam int XSH   = 24;

    localparam logic [XRW-1:0] X_RECIP = XRW'(1118482);

    localparam logic [HW-1:0] DEG60  = HW'(rhr_pkg::DEG60_I  * (1 << F));
    localparam logic [HW-1:0] DEG120 = HW'(rhr_pkg::DEG120_I * (1 << F));
    localparam logic [HW-1:0] DEG180 = HW'(rhr_pkg::DEG180_I * (1 << F));
    localparam logic [HW-1:0] DEG240 = HW'(rhr_pkg::DEG240_I * (1 << F));
    localparam logic [HW-1:0] DEG300 = HW'(rhr_pkg::DEG300_I * (1 << F));
    localparam logic [HW-1:0] DEG360 = HW'(rhr_pkg::DEG360_I * (1 << F));

    logic pipe_en;
    assign pipe_en  = !m_tvalid || m_tready;
    assign s_tready = pipe_en;
    assign cfg_ready = 1'b1;

    logic [rhr_pkg::STEP_W-1:0] step_mod_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_mod_reg <= rhr_pkg::STEP_W'(210);
        end else if (cfg_valid) begin
            step_mod_reg <= (cfg_data >= rhr_pkg::STEP_W'(rhr_pkg::DEG360_I))
                ? cfg_data - rhr_pkg::STEP_W'(rhr_pkg::DEG360_I) : cfg_data;
        end
    end

    // Stage A: max, min, chroma and the numerator of the hue division.
    logic [7:0]          r_in, g_in, b_in, hi, lo, d, pa, pb, n;
    rhr_pkg::base_t      base_sel;
    logic                neg;
    rhr_pkg::hue_side_t  a_side_next, a_side_reg;
    logic [NUMW-1:0]     a_num_next, a_num_reg;
    logic [7:0]          a_div_reg;
    logic                a_vld_reg;

    always_comb begin
        r_in = s_tdata[7:0];
        g_in = s_tdata[15:8];
        b_in = s_tdata[23:16];
        hi = r_in;
        if (g_in > hi) hi = g_in;
        if (b_in > hi) hi = b_in;
        lo = r_in;
        if (g_in < lo) lo = g_in;
        if (b_in < lo) lo = b_in;
        d = hi - lo;
        if (hi == r_in) begin
            pa = g_in; pb = b_in; base_sel = rhr_pkg::BASE_RED;
        end else if (hi == g_in) begin
            pa = b_in; pb = r_in; base_sel = rhr_pkg::BASE_GREEN;
        end else begin
            pa = r_in; pb = g_in; base_sel = rhr_pkg::BASE_BLUE;
        end
        neg = pa < pb;
        n = neg ? pb - pa : pa - pb;
        a_num_next = (NUMW'(n) * NUMW'(60)) << F;
        a_side_next.base   = base_sel;
        a_side_next.neg    = neg;
        a_side_next.zero   = (d == '0);
        a_side_next.chroma = rhr_pkg::q16_of_byte(d);
        a_side_next.mval   = rhr_pkg::q16_of_byte(lo);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_vld_reg <= 1'b0;
        end else if (pipe_en) begin
            a_vld_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            a_num_reg  <= a_num_next;
            a_div_reg  <= (d == '0) ? 8'd1 : d;
            a_side_reg <= a_side_next;
        end
    end

    logic               t_vld;
    logic [TW-1:0]      t_quo;
    logic [HSW-1:0]     t_side_bits;
    rhr_pkg::hue_side_t t_side;

    rhr_div #(.NW(NUMW), .DW(8), .QW(TW), .SW(HSW)) u_hue_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (pipe_en),
        .in_vld   (a_vld_reg),
        .in_num   (a_num_reg),
        .in_div   (a_div_reg),
        .in_side  (a_side_reg),
        .out_vld  (t_vld),
        .out_quo  (t_quo),
        .out_side (t_side_bits)
    );
    assign t_side = rhr_pkg::hue_side_t'(t_side_bits);

    // Stage B: hue and rotation.
    logic [HW-1:0]   basev, h0, h1, h2, b_hue_next, b_hue_reg;
    logic [Q_W-1:0]  b_c_reg, b_m_reg;
    logic            b_vld_reg;

    always_comb begin
        case (t_side.base)
            rhr_pkg::BASE_GREEN: basev = DEG120;
            rhr_pkg::BASE_BLUE:  basev = DEG240;
            default:             basev = '0;
        endcase
        if (t_side.zero) begin
            h0 = '0;
        end else if (t_side.neg) begin
            h0 = ((t_side.base == rhr_pkg::BASE_RED) ? DEG360 : basev) - HW'(t_quo);
        end else begin
            h0 = basev + HW'(t_quo);
        end
        h1 = (h0 >= DEG360) ? h0 - DEG360 : h0;
        h2 = h1 + (HW'(step_mod_reg) << F);
        b_hue_next = (h2 >= DEG360) ? h2 - DEG360 : h2;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_vld_reg <= 1'b0;
        end else if (pipe_en) begin
            b_vld_reg <= t_vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            b_hue_reg <= b_hue_next;
            b_c_reg   <= t_side.chroma;
            b_m_reg   <= t_side.mval;
        end
    end

    // Stage C: sector and position inside it.
    logic [2:0]      sec;
    logic [HW-1:0]   f, gg;
    logic [2:0]      c_sec_reg;
    logic [GW-1:0]   c_gg_reg;
    logic [Q_W-1:0]  c_c_reg, c_m_reg;
    logic            c_vld_reg;

    always_comb begin
        if (b_hue_reg >= DEG300) begin
            sec = 3'd5; f = b_hue_reg - DEG300;
        end else if (b_hue_reg >= DEG240) begin
            sec = 3'd4; f = b_hue_reg - DEG240;
        end else if (b_hue_reg >= DEG180) begin
            sec = 3'd3; f = b_hue_reg - DEG180;
        end else if (b_hue_reg >= DEG120) begin
            sec = 3'd2; f = b_hue_reg - DEG120;
        end else if (b_hue_reg >= DEG60) begin
            sec = 3'd1; f = b_hue_reg - DEG60;
        end else begin
            sec = 3'd0; f = b_hue_reg;
        end
        gg = sec[0] ? DEG60 - f : f;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_vld_reg <= 1'b0;
        end else if (pipe_en) begin
            c_vld_reg <= b_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            c_sec_reg <= sec;
            c_gg_reg  <= gg[GW-1:0];
            c_c_reg   <= b_c_reg;
            c_m_reg   <= b_m_reg;
        end
    end

    // Stage D: chroma times position.
    logic [PW-1:0]       d_prod_reg;
    rhr_pkg::comp_side_t d_side_reg;
    logic                d_vld_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            d_vld_reg <= 1'b0;
        end else if (pipe_en) begin
            d_vld_reg <= c_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            d_prod_reg        <= PW'(c_c_reg) * PW'(c_gg_reg);
            d_side_reg.sector <= c_sec_reg;
            d_side_reg.chroma <= c_c_reg;
            d_side_reg.mval   <= c_m_reg;
        end
    end

    // Stage E: the product over 60 * 2^F, as the product over 4 * 2^F times a reciprocal of 15.
    logic                e_vld_reg;
    logic [XPW-1:0]      e_prod_reg;
    rhr_pkg::comp_side_t e_side_reg;
    logic                e_vld;
    logic [Q_W-1:0]      x_quo;
    rhr_pkg::comp_side_t e_side;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            e_vld_reg <= 1'b0;
        end else if (pipe_en) begin
            e_vld_reg <= d_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            e_prod_reg <= XPW'(d_prod_reg[F+2 +: XMW]) * XPW'(X_RECIP);
            e_side_reg <= d_side_reg;
        end
    end

    assign e_vld  = e_vld_reg;
    assign x_quo  = e_prod_reg[XSH +: Q_W];
    assign e_side = e_side_reg;

    // Stage F: component placement and conversion back to bytes.
    logic [Q_W-1:0] comp_r, comp_g, comp_b;
    logic [7:0]     out_r, out_g, out_b;
    logic [23:0]    out_data_reg;
    logic           out_vld_reg;

    function automatic logic [7:0] to_channel(input logic [Q_W-1:0] comp,
                                              input logic [Q_W-1:0] mv);
        logic [Q_W:0]   s;
        logic [Q_W+8:0] p;
        logic [Q_W-8:0] top;
        s   = {1'b0, comp} + {1'b0, mv};
        p   = ({s, 8'd0}) - (Q_W+9)'(s);
        top = p[Q_W+8:16];
        return (top > (Q_W-7)'(255)) ? 8'd255 : top[7:0];
    endfunction

    always_comb begin
        case (e_side.sector)
            3'd0: begin comp_r = e_side.chroma; comp_g = x_quo; comp_b = '0; end
            3'd1: begin comp_r = x_quo; comp_g = e_side.chroma; comp_b = '0; end
            3'd2: begin comp_r = '0; comp_g = e_side.chroma; comp_b = x_quo; end
            3'd3: begin comp_r = '0; comp_g = x_quo; comp_b = e_side.chroma; end
            3'd4: begin comp_r = x_quo; comp_g = '0; comp_b = e_side.chroma; end
            default: begin comp_r = e_side.chroma; comp_g = '0; comp_b = x_quo; end
        endcase
        out_r = to_channel(comp_r, e_side.mval);
        out_g = to_channel(comp_g, e_side.mval);
        out_b = to_channel(comp_b, e_side.mval);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (pipe_en) begin
            out_vld_reg <= e_vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            out_data_reg <= {out_b, out_g, out_r};
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_data_reg;

    `RHR_ASSERT_NOW(a_step_range, 1'b1, step_mod_reg < rhr_pkg::STEP_W'(rhr_pkg::DEG360_I))
    `RHR_ASSERT_NOW(a_hue_range, b_vld_reg, b_hue_reg < DEG360)
    `RHR_ASSERT_NOW(a_sector_range, e_vld, e_side.sector <= 3'd5)
    `RHR_ASSERT_NEXT(a_stall_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

endmodule

// ===== hw/rtl/rhr_div.sv =====
module rhr_div #(
    parameter int NW = 22,
    parameter int DW = 8,
    parameter int QW = 14,
    parameter int SW = 8
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          en,
    input  logic          in_vld,
    input  logic [NW-1:0] in_num,
    input  logic [DW-1:0] in_div,
    input  logic [SW-1:0] in_side,
    output logic          out_vld,
    output logic [QW-1:0] out_quo,
    output logic [SW-1:0] out_side
);

    logic          vld_reg  [NW+1];
    logic [DW-1:0] rem_reg  [NW+1];
    logic [NW-1:0] nq_reg   [NW+1];
    logic [DW-1:0] div_reg  [NW+1];
    logic [SW-1:0] side_reg [NW+1];

    always_comb begin
        vld_reg[0]  = in_vld;
        rem_reg[0]  = '0;
        nq_reg[0]   = in_num;
        div_reg[0]  = in_div;
        side_reg[0] = in_side;
    end

    for (genvar i = 0; i < NW; i++) begin : g_stage
        logic [DW:0]   trial;
        logic          ge;
        logic [DW:0]   diff;
        logic [DW-1:0] rem_next;
        logic [NW-1:0] nq_next;

        always_comb begin
            trial    = {rem_reg[i], nq_reg[i][NW-1]};
            ge       = trial >= {1'b0, div_reg[i]};
            diff     = trial - {1'b0, div_reg[i]};
            rem_next = ge ? diff[DW-1:0] : trial[DW-1:0];
            nq_next  = {nq_reg[i][NW-2:0], ge};
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[i+1] <= 1'b0;
            end else if (en) begin
                vld_reg[i+1] <= vld_reg[i];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[i+1]  <= rem_next;
                nq_reg[i+1]   <= nq_next;
                div_reg[i+1]  <= div_reg[i];
                side_reg[i+1] <= side_reg[i];
            end
        end
    end

    assign out_vld  = vld_reg[NW];
    assign out_quo  = nq_reg[NW][QW-1:0];
    assign out_side = side_reg[NW];

endmodule
